>>> rtl/rhht_pkg.sv
// Package with shared constants and types for the Robin Hood hash table core.
package rhht_pkg;
    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_W = 32;
    localparam int CNT_W = 16;
    localparam int LOAD_W = 11;
    localparam int SLOT_W = 10;
    localparam int STATUS_W = 2;
    localparam logic [LOAD_W-1:0] MAX_LOAD_RESET = 11'd768;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] case_cnt;
        logic [CNT_W-1:0] ctrl_cnt;
    } entry_t;
endpackage

>>> rtl/rhht_store.sv
// Slot memory with a clearing pass for keys and a registered read port.
module rhht_store import rhht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    output entry_t                      rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  entry_t                      wr_data,
    output logic                        clear_done
);
    localparam int AW = $clog2(CAPACITY);

    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [CNT_W-1:0] case_mem [CAPACITY];
    logic [CNT_W-1:0] ctrl_mem [CAPACITY];
    logic [AW-1:0] clr_addr_reg;
    logic clr_busy_reg;
    logic [AW-1:0] clr_addr_next;
    logic clr_busy_next;

    assign clear_done = !clr_busy_reg;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(CAPACITY - 1))
                clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            key_mem[clr_addr_reg] <= '0;
        else if (wr_en)
            key_mem[wr_addr] <= wr_data.key;
        if (wr_en && !clr_busy_reg)
        begin
            case_mem[wr_addr] <= wr_data.case_cnt;
            ctrl_mem[wr_addr] <= wr_data.ctrl_cnt;
        end
        rd_data.key <= key_mem[rd_addr];
        rd_data.case_cnt <= case_mem[rd_addr];
        rd_data.ctrl_cnt <= ctrl_mem[rd_addr];
    end
endmodule

>>> rtl/robin_hood_hash_table_core.sv
// Top level of the Robin Hood hash table: probe sequencer over one slot memory.
//  channel | direction | fields
//  in      | input     | kind, key, weight, case_flag
//  out     | output    | status, slot, case_total, control_total
//  config  | input     | max_load (write enable and data)
// Each probed slot passes through the address, registered read, and compare and write states.
// An item probes up to CAPACITY slots.
// After reset a clearing pass empties the key memory; no transfer is accepted
// meanwhile. in_stall is high from acceptance until the result transfers.
module robin_hood_hash_table_core import rhht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LOAD_W-1:0]   cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [KEY_W-1:0]    key,
    input  logic [7:0]          weight,
    input  logic                case_flag,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot,
    output logic [CNT_W-1:0]    case_total,
    output logic [CNT_W-1:0]    control_total
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {S_IDLE, S_ADDR, S_READ, S_EVAL, S_OUT} state_t;

    state_t state_reg;
    logic [LOAD_W-1:0] max_load_reg;
    logic [CW-1:0] count_reg;
    logic kind_reg;
    entry_t carry_reg;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] dist_reg;
    logic [CW-1:0] steps_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0] case_reg;
    logic [CNT_W-1:0] ctrl_reg;

    entry_t rd_data;
    logic clear_done;
    logic wr_en;
    entry_t wr_data;
    logic [AW-1:0] res_dist;
    logic accept;
    logic full;

    rhht_store #(.CAPACITY(CAPACITY)) u_store (
        .clk(clk), .rst_n(rst_n), .rd_addr(pos_reg), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(pos_reg), .wr_data(wr_data), .clear_done(clear_done)
    );

    assign in_stall = (state_reg != S_IDLE) || !clear_done;
    assign accept = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign status = status_reg;
    assign slot = slot_reg;
    assign case_total = case_reg;
    assign control_total = ctrl_reg;
    assign res_dist = pos_reg - rd_data.key[AW-1:0];
    assign full = ({{(32-LOAD_W){1'b0}}, max_load_reg} <= 32'(count_reg))
        || (32'(count_reg) >= 32'(CAPACITY));

    always_comb
    begin
        wr_en = 1'b0;
        wr_data = carry_reg;
        if (state_reg == S_EVAL && kind_reg == KIND_INSERT)
            if (rd_data.key == '0 || res_dist < dist_reg)
                wr_en = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            max_load_reg <= MAX_LOAD_RESET;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                max_load_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg <= kind;
                        carry_reg.key <= key;
                        carry_reg.case_cnt <= case_flag ? CNT_W'(weight) : '0;
                        carry_reg.ctrl_cnt <= case_flag ? '0 : CNT_W'(weight);
                        pos_reg <= key[AW-1:0];
                        dist_reg <= '0;
                        steps_reg <= '0;
                        slot_reg <= '0;
                        case_reg <= '0;
                        ctrl_reg <= '0;
                        if (key == '0)
                        begin
                            status_reg <= (kind == KIND_INSERT) ? ST_REJECTED : ST_NOT_FOUND;
                            state_reg <= S_OUT;
                        end
                        else if (kind == KIND_INSERT && full)
                        begin
                            status_reg <= ST_REJECTED;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_ADDR;
                    end
                end
                S_ADDR:
                    state_reg <= S_READ;
                S_READ:
                    state_reg <= S_EVAL;
                S_EVAL:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    dist_reg <= dist_reg + 1'b1;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= S_ADDR;
                    if (kind_reg == KIND_INSERT)
                    begin
                        if (rd_data.key == '0)
                        begin
                            status_reg <= ST_INSERTED;
                            count_reg <= count_reg + 1'b1;
                            state_reg <= S_OUT;
                        end
                        else if (res_dist < dist_reg)
                        begin
                            carry_reg <= rd_data;
                            dist_reg <= res_dist + 1'b1;
                        end
                    end
                    else
                    begin
                        if (rd_data.key == '0 || dist_reg > res_dist)
                        begin
                            status_reg <= ST_NOT_FOUND;
                            state_reg <= S_OUT;
                        end
                        else if (rd_data.key == carry_reg.key)
                        begin
                            status_reg <= ST_FOUND;
                            slot_reg <= SLOT_W'(pos_reg);
                            case_reg <= rd_data.case_cnt;
                            ctrl_reg <= rd_data.ctrl_cnt;
                            state_reg <= S_OUT;
                        end
                        else if (steps_reg == CW'(CAPACITY - 1))
                        begin
                            status_reg <= ST_NOT_FOUND;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                    if (!out_stall)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == S_EVAL && kind_reg == KIND_INSERT)
        else $error("slot write outside an insert probe");
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CAPACITY))
        else $error("element count exceeds capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_reg != ST_FOUND |-> slot_reg == '0)
        else $error("slot set without a found key");
endmodule

>>> dv/testbench.sv
// Self-checking testbench for the Robin Hood hash table core with a behavioral table predictor.
module testbench;
    import rhht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 3 * CAP * 3 + 5000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [CNT_W-1:0]    case_total;
        logic [CNT_W-1:0]    control_total;
    } answer_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [LOAD_W-1:0]   cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                kind = KIND_INSERT;
    logic [KEY_W-1:0]    key = '0;
    logic [7:0]          weight = '0;
    logic                case_flag = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    case_total;
    logic [CNT_W-1:0]    control_total;

    logic [KEY_W-1:0] table_keys [CAP];
    logic [CNT_W-1:0] table_case [CAP];
    logic [CNT_W-1:0] table_ctrl [CAP];
    int unsigned      stored_count;
    logic [LOAD_W-1:0] load_limit;
    answer_t          pending_answers [$];
    logic [KEY_W-1:0] inserted_keys [$];
    int               error_count = 0;
    int               idle_cycles = 0;
    int               hold_cycles = 0;
    bit               random_stall = 1'b1;
    int               stall_left = 0;
    bit               wait_drawn = 1'b0;
    int unsigned      wait_draw;

    robin_hood_hash_table_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .key(key),
        .weight(weight), .case_flag(case_flag),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .slot(slot), .case_total(case_total), .control_total(control_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned chain_offset(logic [KEY_W-1:0] k, int unsigned pos);
        return (pos + CAP - (k % CAP)) % CAP;
    endfunction

    function automatic void table_clear();
        for (int i = 0; i < CAP; i++)
        begin
            table_keys[i] = '0;
            table_case[i] = '0;
            table_ctrl[i] = '0;
        end
        stored_count = 0;
        load_limit = MAX_LOAD_RESET;
    endfunction

    function automatic void table_place(logic [KEY_W-1:0] k, logic [CNT_W-1:0] cs,
                                        logic [CNT_W-1:0] ct);
        int unsigned pos;
        int unsigned walk;
        int unsigned rd;
        logic [KEY_W-1:0] tk;
        logic [CNT_W-1:0] tcs;
        logic [CNT_W-1:0] tct;
        pos = k % CAP;
        walk = 0;
        for (int n = 0; n < CAP; n++)
        begin
            if (table_keys[pos] == '0)
            begin
                table_keys[pos] = k;
                table_case[pos] = cs;
                table_ctrl[pos] = ct;
                return;
            end
            rd = chain_offset(table_keys[pos], pos);
            if (rd < walk)
            begin
                tk = table_keys[pos];
                tcs = table_case[pos];
                tct = table_ctrl[pos];
                table_keys[pos] = k;
                table_case[pos] = cs;
                table_ctrl[pos] = ct;
                k = tk;
                cs = tcs;
                ct = tct;
                walk = rd;
            end
            pos = (pos + 1) % CAP;
            walk++;
        end
    endfunction

    function automatic answer_t table_operation(logic op, logic [KEY_W-1:0] k,
                                                logic [7:0] allele, logic is_case);
        answer_t a;
        int unsigned pos;
        int unsigned walk;
        a = '0;
        if (op == KIND_INSERT)
        begin
            if (k == '0 || stored_count >= load_limit || stored_count >= CAP)
                a.status = ST_REJECTED;
            else
            begin
                if (is_case)
                    table_place(k, {8'd0, allele}, '0);
                else
                    table_place(k, '0, {8'd0, allele});
                stored_count++;
                a.status = ST_INSERTED;
            end
            return a;
        end
        a.status = ST_NOT_FOUND;
        if (k == '0)
            return a;
        pos = k % CAP;
        walk = 0;
        for (int n = 0; n < CAP; n++)
        begin
            if (table_keys[pos] == '0 || walk > chain_offset(table_keys[pos], pos))
                return a;
            if (table_keys[pos] == k)
            begin
                a.status = ST_FOUND;
                a.slot = pos[SLOT_W-1:0];
                a.case_total = table_case[pos];
                a.control_total = table_ctrl[pos];
                return a;
            end
            pos = (pos + 1) % CAP;
            walk++;
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("unexpected result, status", int'(status), 0);
            else
            begin
                answer_t w;
                w = pending_answers.pop_front();
                if (status !== w.status)
                    report_mismatch("status", int'(status), int'(w.status));
                if (slot !== w.slot)
                    report_mismatch("slot", int'(slot), int'(w.slot));
                if (case_total !== w.case_total)
                    report_mismatch("case_total", int'(case_total), int'(w.case_total));
                if (control_total !== w.control_total)
                    report_mismatch("control_total", int'(control_total),
                                    int'(w.control_total));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (!out_valid)
        begin
            wait_drawn <= 1'b0;
            stall_left <= 0;
            out_stall <= 1'b0;
        end
        else if (!wait_drawn)
        begin
            wait_draw = random_stall ? $urandom_range(0, 14) : 0;
            wait_drawn <= 1'b1;
            stall_left <= (wait_draw != 0) ? int'(wait_draw) - 1 : 0;
            out_stall <= (wait_draw != 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_item(logic op, logic [KEY_W-1:0] k, logic [7:0] allele, logic is_case,
                             bit gaps = 1'b1);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        if ($urandom_range(0, 2) == 0) gap = 0;
        @(negedge clk);
        repeat (gap) @(negedge clk);
        kind <= op;
        key <= k;
        weight <= allele;
        case_flag <= is_case;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        pending_answers.push_back(table_operation(op, k, allele, is_case));
        if (op == KIND_INSERT && k != '0) inserted_keys.push_back(k);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_answers.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_load_limit(logic [LOAD_W-1:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        load_limit = v;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5 && inserted_keys.size() != 0)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        if (r < 8)
            return {22'($urandom), 5'd0, 5'($urandom_range(0, 31))};
        return $urandom;
    endfunction

    task automatic test_directed();
        send_item(KIND_LOOKUP, 32'd5, 8'd0, 1'b0);
        send_item(KIND_INSERT, 32'd0, 8'hFF, 1'b1);
        send_item(KIND_LOOKUP, 32'd0, 8'd0, 1'b0);
        send_item(KIND_INSERT, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_item(KIND_INSERT, 32'h0000_03FF, 8'h00, 1'b0);
        send_item(KIND_INSERT, 32'h0000_07FF, 8'hA5, 1'b0);
        send_item(KIND_INSERT, 32'h0000_0400, 8'h5A, 1'b1);
        send_item(KIND_INSERT, 32'h0000_0001, 8'd1, 1'b1);
        send_item(KIND_INSERT, 32'h0000_0400, 8'd2, 1'b0);
        send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 8'd0, 1'b0);
        send_item(KIND_LOOKUP, 32'h0000_07FF, 8'd0, 1'b0);
        send_item(KIND_LOOKUP, 32'h0000_0400, 8'd0, 1'b0);
        send_item(KIND_LOOKUP, 32'h0000_0001, 8'd0, 1'b1);
        send_item(KIND_LOOKUP, 32'h8000_0400, 8'd0, 1'b0);
        send_item(KIND_LOOKUP, 32'h0000_0002, 8'd0, 1'b0);
    endtask

    task automatic test_load_limit();
        write_load_limit(11'd1);
        send_item(KIND_INSERT, 32'h1234_5678, 8'd9, 1'b1);
        send_item(KIND_LOOKUP, 32'h1234_5678, 8'd0, 1'b0);
        write_load_limit(11'd12);
        for (int i = 0; i < 6; i++)
            send_item(KIND_INSERT, pick_key() | 32'd1, 8'($urandom), 1'($urandom), 1'b0);
    endtask

    task automatic test_backpressure();
        drain();
        hold_cycles <= 300;
        for (int i = 0; i < 6; i++)
            send_item(1'($urandom), pick_key(), 8'($urandom), 1'($urandom), 1'b0);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 4) random_stall = 1'b0;
            if (i == count / 3) random_stall = 1'b1;
            if ($urandom_range(0, 19) == 0)
                send_item(1'($urandom), $urandom_range(0, 1) ? 32'd0 : $urandom,
                          8'($urandom), 1'($urandom),
                          i >= count / 4 && i < count / 3 ? 1'b0 : 1'b1);
            else
                send_item(1'($urandom_range(0, 1)), pick_key(), 8'($urandom), 1'($urandom),
                          i >= count / 4 && i < count / 3 ? 1'b0 : 1'b1);
        end
    endtask

    task automatic test_fill_limits();
        write_load_limit(11'd1024);
        for (int i = 0; i < 200; i++)
            send_item($urandom_range(0, 3) != 0 ? KIND_INSERT : KIND_LOOKUP,
                      pick_key(), 8'($urandom), 1'($urandom), 1'b0);
        write_load_limit(11'd200);
        for (int i = 0; i < 30; i++)
            send_item(1'($urandom_range(0, 1)), pick_key(), 8'($urandom), 1'($urandom));
    endtask

    initial
    begin
        table_clear();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_load_limit();
        test_backpressure();
        write_load_limit(MAX_LOAD_RESET);
        test_random(480);
        test_fill_limits();
        drain();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
